// ----- rtl/plfd_pkg.sv -----
// ----------------------------------------------------------------------------
// plfd_pkg
// Types and constants shared by the line follower drive controller.
// ----------------------------------------------------------------------------
package plfd_pkg;

	localparam int ERR_W   = 11;
	localparam int DER_W   = 12;
	localparam int INTEG_W = 16;
	localparam int GAIN_W  = 16;
	localparam int SPD_W   = 12;
	localparam int POS_W   = 24;
	localparam int PP_W    = GAIN_W + 1 + ERR_W - 1;
	localparam int PI_W    = GAIN_W + 1 + INTEG_W;
	localparam int PD_W    = GAIN_W + 1 + DER_W - 1;
	localparam int SUM_W   = PI_W + 3;
	localparam int INTEG_SUM_W = INTEG_W + 2;
	localparam int LEAK_SHIFT  = 3;

	typedef enum logic [2:0] {
		REG_STOP_MODE       = 3'd0,
		REG_CRUISE_SPEED    = 3'd1,
		REG_DISTANCE_TARGET = 3'd2,
		REG_ERROR_OFFSET    = 3'd3,
		REG_GAIN_P          = 3'd4,
		REG_GAIN_I          = 3'd5,
		REG_GAIN_D          = 3'd6,
		REG_RANGE_THRESHOLD = 3'd7
	} plfd_reg_t;

	localparam logic              RST_STOP_MODE       = 1'b0;
	localparam logic signed [11:0] RST_CRUISE_SPEED   = 12'sd1100;
	localparam logic signed [23:0] RST_DISTANCE_TARGET = 24'sd0;
	localparam logic [9:0]        RST_ERROR_OFFSET    = 10'd823;
	localparam logic [15:0]       RST_GAIN_P          = 16'd614;
	localparam logic [15:0]       RST_GAIN_I          = 16'd26;
	localparam logic [15:0]       RST_GAIN_D          = 16'd2099;
	localparam logic [11:0]       RST_RANGE_THRESHOLD = 12'd650;

	typedef struct packed {
		logic                    start_req;
		logic [9:0]              line_sample;
		logic [11:0]             range_sample;
		logic signed [POS_W-1:0] motor_position;
	} plfd_sample_t;

	typedef struct packed {
		logic signed [SPD_W-1:0] left_speed;
		logic signed [SPD_W-1:0] right_speed;
		logic                    done_res;
	} plfd_result_t;

	typedef struct packed {
		plfd_reg_t   index;
		logic [23:0] value;
	} plfd_cfg_wr_t;

	typedef struct packed {
		logic                    stop_mode;
		logic signed [SPD_W-1:0] cruise_speed;
		logic signed [POS_W-1:0] distance_target;
		logic [9:0]              error_offset;
		logic [GAIN_W-1:0]       gain_p;
		logic [GAIN_W-1:0]       gain_i;
		logic [GAIN_W-1:0]       gain_d;
		logic [11:0]             range_threshold;
	} plfd_regs_t;

endpackage

// ----- rtl/plfd_chan_if.sv -----
// ----------------------------------------------------------------------------
// plfd_chan_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface plfd_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/plfd_cfg.sv -----
// ----------------------------------------------------------------------------
// plfd_cfg
// Configuration register file; always ready, one register per write.
// ----------------------------------------------------------------------------
module plfd_cfg (
	input  logic               clk,
	input  logic               arst_n,
	plfd_chan_if.sink          cfg,
	output plfd_pkg::plfd_regs_t regs
);
	import plfd_pkg::*;

	plfd_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.stop_mode       <= RST_STOP_MODE;
			regs_q.cruise_speed    <= RST_CRUISE_SPEED;
			regs_q.distance_target <= RST_DISTANCE_TARGET;
			regs_q.error_offset    <= RST_ERROR_OFFSET;
			regs_q.gain_p          <= RST_GAIN_P;
			regs_q.gain_i          <= RST_GAIN_I;
			regs_q.gain_d          <= RST_GAIN_D;
			regs_q.range_threshold <= RST_RANGE_THRESHOLD;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_STOP_MODE:       regs_q.stop_mode       <= cfg.data.value[0];
				REG_CRUISE_SPEED:    regs_q.cruise_speed    <= cfg.data.value[11:0];
				REG_DISTANCE_TARGET: regs_q.distance_target <= cfg.data.value[23:0];
				REG_ERROR_OFFSET:    regs_q.error_offset    <= cfg.data.value[9:0];
				REG_GAIN_P:          regs_q.gain_p          <= cfg.data.value[15:0];
				REG_GAIN_I:          regs_q.gain_i          <= cfg.data.value[15:0];
				REG_GAIN_D:          regs_q.gain_d          <= cfg.data.value[15:0];
				REG_RANGE_THRESHOLD: regs_q.range_threshold <= cfg.data.value[11:0];
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/pid_line_follow_drive.sv -----
// ----------------------------------------------------------------------------
// pid_line_follow_drive
// PID line follower for a differential drive.
//
// Channels: sample (sink) takes one control tick per item: start request,
// line sample, range sample and motor position. result (source) returns one
// item per tick: left and right speed commands and the done flag. cfg (sink)
// writes one register per item and is always ready; write it only while idle.
// Pipeline: stage 1, stage 2, output register. Throughput: one tick per
// cycle while results are taken. Controller state (integral, last error,
// done) updates as the tick is accepted, so the next tick may follow at once;
// the three gain products sit in their own stage before the speed sum.
// Reset: registers take their defaults, integral, last error, done and the
// held speeds clear, and the pipeline empties.
// Stall: each of the three stages holds while the one after it is full, so
// up to three ticks are taken while result.ready stays low, then sample.ready
// drops.
// ----------------------------------------------------------------------------
module pid_line_follow_drive #(
	parameter int GAIN_FRAC_BITS = 8,
	parameter int SPEED_LIMIT    = 1500
) (
	input logic       clk,
	input logic       arst_n,
	plfd_chan_if.sink   sample,
	plfd_chan_if.source result,
	plfd_chan_if.sink   cfg
);
	import plfd_pkg::*;

	localparam int LIM_W = SUM_W + 1;
	localparam logic signed [LIM_W-1:0] LIM_HI = LIM_W'(SPEED_LIMIT);
	localparam logic signed [LIM_W-1:0] LIM_LO = -LIM_HI;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);
	localparam logic signed [INTEG_SUM_W-1:0] INTEG_MAX = INTEG_SUM_W'(32767);
	localparam logic signed [INTEG_SUM_W-1:0] INTEG_MIN = -INTEG_SUM_W'(32768);

	plfd_regs_t   regs;
	plfd_sample_t smp;

	plfd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// controller state
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic                      finished_q;
	logic signed [SPD_W-1:0]   held_left_q;
	logic signed [SPD_W-1:0]   held_right_q;

	// stage 1
	logic                      v_s1, hold_s1;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [INTEG_W-1:0] integ_s1;
	logic signed [DER_W-1:0]   der_s1;

	// stage 2
	logic                   v_s2, hold_s2;
	logic signed [PP_W-1:0] prod_p_s2;
	logic signed [PI_W-1:0] prod_i_s2;
	logic signed [PD_W-1:0] prod_d_s2;

	// output register
	logic         v_q;
	plfd_result_t res_q;

	logic adv_q, adv_s2, adv_s1, take;

	assign adv_q  = !v_q || result.ready;
	assign adv_s2 = !v_s2 || adv_q;
	assign adv_s1 = !v_s1 || adv_s2;
	assign take   = sample.valid && adv_s1;

	assign sample.ready = adv_s1;
	assign result.valid = v_q;
	assign result.data  = res_q;
	assign smp          = sample.data;

	// tick front end: stop test, error, integral, derivative
	logic                          fin_eff, stop, run;
	logic signed [INTEG_W-1:0]     integ_base;
	logic signed [ERR_W-1:0]       prev_base, err;
	logic signed [INTEG_SUM_W-1:0] integ_sum;
	logic signed [INTEG_W-1:0]     integ_new;
	logic signed [DER_W-1:0]       der;

	always_comb begin
		fin_eff    = smp.start_req ? 1'b0 : finished_q;
		integ_base = smp.start_req ? '0 : integ_q;
		prev_base  = smp.start_req ? '0 : prev_err_q;
		stop       = regs.stop_mode ? (smp.range_sample <= regs.range_threshold)
		                            : (smp.motor_position >= regs.distance_target);
		run        = !fin_eff && !stop;
		err        = $signed({1'b0, smp.line_sample}) - $signed({1'b0, regs.error_offset});
		integ_sum  = INTEG_SUM_W'(integ_base) - INTEG_SUM_W'(integ_base >>> LEAK_SHIFT)
		           + INTEG_SUM_W'(err);
		if (integ_sum > INTEG_MAX)
			integ_new = INTEG_MAX[INTEG_W-1:0];
		else if (integ_sum < INTEG_MIN)
			integ_new = INTEG_MIN[INTEG_W-1:0];
		else
			integ_new = integ_sum[INTEG_W-1:0];
		der = DER_W'(err) - DER_W'(prev_base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
			finished_q <= 1'b0;
		end else if (take) begin
			finished_q <= !run;
			integ_q    <= run ? integ_new : integ_base;
			prev_err_q <= run ? err : prev_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_s1  <= !run;
			err_s1   <= err;
			integ_s1 <= integ_new;
			der_s1   <= der;
		end
	end

	// gain products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			hold_s2   <= hold_s1;
			prod_p_s2 <= PP_W'(err_s1) * $signed(PP_W'({1'b0, regs.gain_p}));
			prod_i_s2 <= PI_W'(integ_s1) * $signed(PI_W'({1'b0, regs.gain_i}));
			prod_d_s2 <= PD_W'(der_s1) * $signed(PD_W'({1'b0, regs.gain_d}));
		end
	end

	// sum, scale toward zero, steer and saturate
	logic signed [SUM_W-1:0] pid_sum, turn;
	logic signed [LIM_W-1:0] left_w, right_w;
	logic signed [SPD_W-1:0] left_new, right_new;

	always_comb begin
		pid_sum = SUM_W'(prod_p_s2) + SUM_W'(prod_i_s2) + SUM_W'(prod_d_s2);
		turn    = (pid_sum + (pid_sum[SUM_W-1] ? ROUND_BIAS : SUM_W'(0))) >>> GAIN_FRAC_BITS;
		left_w  = LIM_W'(regs.cruise_speed) + LIM_W'(turn);
		right_w = LIM_W'(regs.cruise_speed) - LIM_W'(turn);
		if (left_w > LIM_HI)
			left_new = LIM_HI[SPD_W-1:0];
		else if (left_w < LIM_LO)
			left_new = LIM_LO[SPD_W-1:0];
		else
			left_new = left_w[SPD_W-1:0];
		if (right_w > LIM_HI)
			right_new = LIM_HI[SPD_W-1:0];
		else if (right_w < LIM_LO)
			right_new = LIM_LO[SPD_W-1:0];
		else
			right_new = right_w[SPD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q          <= 1'b0;
			held_left_q  <= '0;
			held_right_q <= '0;
		end else begin
			if (adv_q)
				v_q <= v_s2;
			if (adv_q && v_s2 && !hold_s2) begin
				held_left_q  <= left_new;
				held_right_q <= right_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_q && v_s2) begin
			res_q.done_res    <= hold_s2;
			res_q.left_speed  <= hold_s2 ? held_left_q : left_new;
			res_q.right_speed <= hold_s2 ? held_right_q : right_new;
		end
	end
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Testbench for the PID line follower drive controller. A directed table
// covers sample and register extremes, start, stop on distance and on range,
// stopped ticks and held speeds. Random phases follow, each under a fresh
// register setting, mostly made of start/run/stop trips with noise mixed in.
// Table rows give some results; a software copy of the controller predicts
// the rest, compared field by field in order. Both sides idle at random, and
// the result side holds off once for a long stretch so the pipeline fills.
// ----------------------------------------------------------------------------
module testbench;
	import plfd_pkg::*;

	localparam int  LAT       = 3;
	localparam int  FRAC_BITS = 8;
	localparam int  SPD_LIM   = 1500;
	localparam int  PHASES    = 10;
	localparam int  PHASE_LEN = 85;
	localparam int  HOLD_LEN  = 40;
	localparam int  IDLE_PCT  = 34;

	typedef struct {
		bit           wr;
		plfd_reg_t    idx;
		logic [23:0]  val;
		plfd_sample_t s;
		bit           typed;
		plfd_result_t want;
	} drive_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plfd_chan_if #(.T(plfd_sample_t)) sample_ch ();
	plfd_chan_if #(.T(plfd_result_t)) result_ch ();
	plfd_chan_if #(.T(plfd_cfg_wr_t)) cfg_ch ();

	pid_line_follow_drive dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// controller copy
	plfd_regs_t         regs;
	logic signed [15:0] integ;
	logic signed [10:0] last_err;
	bit                 stopped;
	logic signed [11:0] hold_l, hold_r;

	plfd_result_t speed_q[$];
	drive_row_t   dir_tab[$];

	int n_ticks, n_results, n_done, n_writes, n_errors;
	int trip, linger;
	int hold_cnt;
	bit hold_used;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void reset_model();
		regs.stop_mode       = RST_STOP_MODE;
		regs.cruise_speed    = RST_CRUISE_SPEED;
		regs.distance_target = RST_DISTANCE_TARGET;
		regs.error_offset    = RST_ERROR_OFFSET;
		regs.gain_p          = RST_GAIN_P;
		regs.gain_i          = RST_GAIN_I;
		regs.gain_d          = RST_GAIN_D;
		regs.range_threshold = RST_RANGE_THRESHOLD;
		integ = '0;
		last_err = '0;
		stopped = 1'b0;
		hold_l = '0;
		hold_r = '0;
	endfunction

	function automatic void apply_reg(plfd_reg_t idx, logic [23:0] v);
		case (idx)
			REG_STOP_MODE:       regs.stop_mode = v[0];
			REG_CRUISE_SPEED:    regs.cruise_speed = v[11:0];
			REG_DISTANCE_TARGET: regs.distance_target = v;
			REG_ERROR_OFFSET:    regs.error_offset = v[9:0];
			REG_GAIN_P:          regs.gain_p = v[15:0];
			REG_GAIN_I:          regs.gain_i = v[15:0];
			REG_GAIN_D:          regs.gain_d = v[15:0];
			REG_RANGE_THRESHOLD: regs.range_threshold = v[11:0];
			default: ;
		endcase
	endfunction

	function automatic plfd_result_t steer_step(plfd_sample_t s);
		longint e, acc, der, lsum, turn, base;
		bit hit;
		plfd_result_t r;
		if (s.start_req) begin
			integ = '0;
			last_err = '0;
			stopped = 1'b0;
		end
		if (!stopped) begin
			if (regs.stop_mode)
				hit = longint'(s.range_sample) <= longint'(regs.range_threshold);
			else
				hit = longint'($signed(s.motor_position)) >=
				      longint'($signed(regs.distance_target));
			if (hit) begin
				stopped = 1'b1;
			end else begin
				e = longint'(s.line_sample) - longint'(regs.error_offset);
				acc = longint'(integ);
				acc = clip(acc - (acc >>> 3) + e, -32768, 32767);
				integ = 16'(acc);
				der = e - longint'(last_err);
				lsum = longint'(regs.gain_p) * e + longint'(regs.gain_i) * acc +
				       longint'(regs.gain_d) * der;
				turn = lsum / (longint'(1) << FRAC_BITS);
				base = longint'($signed(regs.cruise_speed));
				hold_l = 12'(clip(base + turn, -SPD_LIM, SPD_LIM));
				hold_r = 12'(clip(base - turn, -SPD_LIM, SPD_LIM));
				last_err = 11'(e);
			end
		end
		r.left_speed = hold_l;
		r.right_speed = hold_r;
		r.done_res = stopped;
		return r;
	endfunction

	function automatic drive_row_t tick_row(bit st, int line, int rng, int pos,
			bit typed = 0, int l = 0, int r = 0, bit d = 0);
		drive_row_t w;
		w.wr = 1'b0;
		w.idx = REG_STOP_MODE;
		w.val = '0;
		w.s.start_req = st;
		w.s.line_sample = 10'(line);
		w.s.range_sample = 12'(rng);
		w.s.motor_position = 24'(pos);
		w.typed = typed;
		w.want.left_speed = 12'(l);
		w.want.right_speed = 12'(r);
		w.want.done_res = d;
		return w;
	endfunction

	function automatic drive_row_t reg_row(plfd_reg_t idx, int v);
		drive_row_t w;
		w = tick_row(0, 0, 0, 0);
		w.wr = 1'b1;
		w.idx = idx;
		w.val = 24'(v);
		return w;
	endfunction

	function automatic int pick(int lo, int hi);
		case ($urandom_range(7))
			0: return lo;
			1: return hi;
			default: return lo + int'($urandom_range(hi - lo));
		endcase
	endfunction

	function automatic plfd_sample_t next_tick();
		plfd_sample_t s;
		longint p, step;
		s.start_req = 1'b0;
		s.line_sample = 10'($urandom);
		s.range_sample = 12'($urandom);
		s.motor_position = 24'($urandom);
		if ($urandom_range(9) == 0) begin
			s.start_req = ($urandom_range(7) == 0);
			return s;
		end
		if ($urandom_range(1))
			s.line_sample = 10'(clip(longint'(regs.error_offset) +
				$signed($urandom_range(128)) - 64, 0, 1023));
		if (trip <= -linger) begin
			trip = $urandom_range(40, 2);
			linger = $urandom_range(4, 1);
			s.start_req = 1'b1;
		end
		step = $urandom_range(500, 1);
		if (regs.stop_mode) begin
			p = longint'(regs.range_threshold);
			p = trip > 0 ? p + trip * (step % 64 + 1) : p - $urandom_range(20);
			s.range_sample = 12'(clip(p, 0, 4095));
		end else begin
			p = longint'($signed(regs.distance_target));
			p = trip > 0 ? p - trip * step : p + $urandom_range(50);
			s.motor_position = 24'(clip(p, -8388608, 8388607));
		end
		trip--;
		return s;
	endfunction

	task automatic send_tick(plfd_sample_t s, bit typed, plfd_result_t want);
		plfd_result_t r;
		while (!(n_ticks >= 300 && n_ticks < 420) && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do @(posedge clk); while (!sample_ch.ready);
		r = steer_step(s);
		speed_q.push_back(typed ? want : r);
		n_ticks++;
	endtask

	task automatic write_reg(plfd_reg_t idx, logic [23:0] v);
		plfd_cfg_wr_t w;
		w.index = idx;
		w.value = v;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, v);
		n_writes++;
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (speed_q.size() != 0)
			@(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	task automatic reconfigure();
		write_reg(REG_STOP_MODE, 24'($urandom_range(1)));
		write_reg(REG_CRUISE_SPEED, 24'($urandom_range(3) == 0 ?
			pick(-2048, 2047) : pick(-1500, 1500)));
		write_reg(REG_DISTANCE_TARGET, 24'(pick(-8388608, 8388607)));
		write_reg(REG_ERROR_OFFSET, 24'(pick(0, 1023)));
		write_reg(REG_GAIN_P, 24'(pick(0, 65535) >> $urandom_range(8)));
		write_reg(REG_GAIN_I, 24'(pick(0, 65535) >> $urandom_range(8)));
		write_reg(REG_GAIN_D, 24'(pick(0, 65535) >> $urandom_range(8)));
		write_reg(REG_RANGE_THRESHOLD, 24'(pick(0, 4095)));
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: ready pattern and checking
	always @(posedge clk) begin
		plfd_result_t got, want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				n_results++;
				if (got.done_res)
					n_done++;
				if (speed_q.size() == 0) begin
					$display("%0t: result with nothing expected: left %0d right %0d done %0d",
						$time, $signed(got.left_speed), $signed(got.right_speed),
						got.done_res);
					n_errors++;
				end else begin
					want = speed_q.pop_front();
					if (got.left_speed !== want.left_speed) begin
						$display("%0t: left_speed expected %0d actual %0d", $time,
							$signed(want.left_speed), $signed(got.left_speed));
						n_errors++;
					end
					if (got.right_speed !== want.right_speed) begin
						$display("%0t: right_speed expected %0d actual %0d", $time,
							$signed(want.right_speed), $signed(got.right_speed));
						n_errors++;
					end
					if (got.done_res !== want.done_res) begin
						$display("%0t: done_res expected %0d actual %0d", $time,
							want.done_res, got.done_res);
						n_errors++;
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_ch.ready <= 1'b0;
			end else if (!hold_used && n_results >= 600) begin
				hold_used = 1'b1;
				hold_cnt = HOLD_LEN - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (n_results >= 300 && n_results < 420) ||
				                   ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d items still expected", speed_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		bit in_cfg;
		plfd_result_t none;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		none = '0;
		in_cfg = 1'b0;
		trip = 0;
		linger = 0;
		reset_model();

		// after reset: target 0, so position 0 stops at once with zero speeds
		dir_tab.push_back(tick_row(0, 0, 0, 0, 1, 0, 0, 1));
		dir_tab.push_back(tick_row(0, 1023, 4095, -8388608, 1, 0, 0, 1));
		dir_tab.push_back(tick_row(1, 823, 0, -1, 1, 1100, 1100, 0));
		dir_tab.push_back(tick_row(0, 1023, 4095, -8388608));
		dir_tab.push_back(tick_row(0, 0, 0, -5));
		dir_tab.push_back(tick_row(0, 1023, 2730, -1000));
		dir_tab.push_back(tick_row(0, 'h155, 'h555, 'hAAAAAA));
		dir_tab.push_back(tick_row(0, 'h2AA, 'hAAA, 'h800000));
		dir_tab.push_back(tick_row(0, 500, 100, 8388607));
		dir_tab.push_back(tick_row(1, 600, 100, 0));
		dir_tab.push_back(reg_row(REG_GAIN_P, 65535));
		dir_tab.push_back(reg_row(REG_GAIN_I, 65535));
		dir_tab.push_back(reg_row(REG_GAIN_D, 65535));
		dir_tab.push_back(tick_row(1, 1023, 0, -1, 1, 1500, -1500, 0));
		dir_tab.push_back(tick_row(1, 0, 0, -1, 1, -1500, 1500, 0));
		dir_tab.push_back(reg_row(REG_STOP_MODE, 1));
		dir_tab.push_back(tick_row(1, 823, 651, 8388607, 1, 1100, 1100, 0));
		dir_tab.push_back(tick_row(0, 900, 4095, 0));
		dir_tab.push_back(tick_row(0, 100, 650, 0));
		dir_tab.push_back(tick_row(0, 1023, 4095, 0));
		dir_tab.push_back(reg_row(REG_CRUISE_SPEED, -2048));
		dir_tab.push_back(tick_row(1, 823, 4095, 0, 1, -1500, -1500, 0));
		dir_tab.push_back(reg_row(REG_RANGE_THRESHOLD, 4095));
		dir_tab.push_back(tick_row(0, 0, 4095, 0, 1, -1500, -1500, 1));
		dir_tab.push_back(reg_row(REG_RANGE_THRESHOLD, 0));
		dir_tab.push_back(tick_row(1, 823, 0, 0, 1, -1500, -1500, 1));
		dir_tab.push_back(reg_row(REG_DISTANCE_TARGET, -8388608));
		dir_tab.push_back(reg_row(REG_ERROR_OFFSET, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].wr) begin
				if (!in_cfg)
					settle();
				in_cfg = 1'b1;
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				if (in_cfg)
					cfg_ch.valid <= 1'b0;
				in_cfg = 1'b0;
				send_tick(dir_tab[i].s, dir_tab[i].typed, dir_tab[i].want);
			end
		end
		if (in_cfg)
			cfg_ch.valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			reconfigure();
			trip = 0;
			linger = 0;
			for (int k = 0; k < PHASE_LEN; k++)
				send_tick(next_tick(), 1'b0, none);
		end
		settle();

		$display("covered %0d ticks under %0d register writes in %0d random settings",
			n_ticks, n_writes, PHASES);
		$display("checked %0d results, %0d of them stopped with held speeds",
			n_results, n_done);
		if (n_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
